@@ rtl/core/magnetic_heading_atan2_core_assert.svh @@
// Assertion macros used by the checker module of the heading core.
`ifndef MAGNETIC_HEADING_ATAN2_CORE_ASSERT_SVH
`define MAGNETIC_HEADING_ATAN2_CORE_ASSERT_SVH

// Same-cycle implication, checked at the rising clock edge outside reset.
`define HMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heading core assertion failed");

// Next-cycle implication, checked at the rising clock edge outside reset.
`define HMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heading core assertion failed");

`endif

@@ rtl/core/hma_pkg.sv @@
// Package with the types and constants of the heading core.
`timescale 1ns / 1ps
package hma_pkg;

  localparam int unsigned HMA_IN_W      = 16;
  localparam int unsigned HMA_HEADING_W = 15;
  localparam int unsigned HMA_ZFRAC     = 20;
  // Vector datapath: 17 integer bits after pre-rotation, CORDIC gain, 20 fraction bits.
  localparam int unsigned HMA_XW        = 40;
  // Angle accumulator in degrees with 20 fraction bits, range about -100 to 280 degrees.
  localparam int unsigned HMA_ZW        = 32;
  localparam int unsigned HMA_TABLE_LEN = 24;
  localparam int          HMA_HALF_TURN_DEG = 180;
  localparam int          HMA_FULL_TURN_DEG = 360;

  // atan(2^-i) in degrees with 20 fraction bits, rounded to nearest.
  localparam int HMA_ATAN_Q20 [HMA_TABLE_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic                     valid;
    logic                     zero;
    logic signed [HMA_XW-1:0] x;
    logic signed [HMA_XW-1:0] y;
    logic signed [HMA_ZW-1:0] z;
  } hma_stage_t;

endpackage

@@ rtl/core/hma_if.sv @@
// Stream interfaces for magnetometer samples and heading results.
`timescale 1ns / 1ps
interface hma_sample_if;
  import hma_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [HMA_IN_W-1:0] axis_x;
  logic signed [HMA_IN_W-1:0] axis_y;
  logic signed [HMA_IN_W-1:0] axis_z;
  modport source (output valid, output axis_x, output axis_y, output axis_z, input ready);
  modport sink (input valid, input axis_x, input axis_y, input axis_z, output ready);
endinterface

interface hma_heading_if;
  import hma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [HMA_HEADING_W-1:0] heading;
  logic                     vector_zero;
  modport source (output valid, output heading, output vector_zero, input ready);
  modport sink (input valid, input heading, input vector_zero, output ready);
endinterface

@@ rtl/core/hma_pre_cell.sv @@
// Entry cell: scales the sample, folds the left half plane and flags a zero vector.
`timescale 1ns / 1ps
module hma_pre_cell import hma_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [HMA_IN_W-1:0] axis_x_i,
  input  logic signed [HMA_IN_W-1:0] axis_y_i,
  output logic                       ready_o,
  input  logic                       take_i,
  output hma_stage_t                 stage_o
);

  localparam logic signed [HMA_ZW-1:0] HalfTurnZ = HMA_ZW'(HMA_HALF_TURN_DEG <<< HMA_ZFRAC);

  logic                     valid_q;
  hma_stage_t               data_q, data_d;
  logic signed [HMA_XW-1:0] x_s, y_s;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    x_s = HMA_XW'(axis_x_i) <<< HMA_ZFRAC;
    y_s = HMA_XW'(axis_y_i) <<< HMA_ZFRAC;
    data_d       = '0;
    data_d.valid = 1'b1;
    data_d.zero  = (axis_x_i == '0) && (axis_y_i == '0);
    if (x_s < 0) begin
      data_d.x = -x_s;
      data_d.y = -y_s;
      data_d.z = HalfTurnZ;
    end else begin
      data_d.x = x_s;
      data_d.y = y_s;
      data_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule

@@ rtl/core/hma_cordic_cell.sv @@
// One vectoring CORDIC rotation cell with its own pipeline register.
`timescale 1ns / 1ps
module hma_cordic_cell import hma_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hma_stage_t stage_i,
  output logic       ready_o,
  input  logic       take_i,
  output hma_stage_t stage_o
);

  localparam logic signed [HMA_ZW-1:0] AtanZ = HMA_ZW'(HMA_ATAN_Q20[IDX]);

  logic                     valid_q;
  hma_stage_t               data_q, data_d;
  logic signed [HMA_XW-1:0] x_s, y_s, dx, dy;
  logic signed [HMA_ZW-1:0] z_s;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    x_s = stage_i.x;
    y_s = stage_i.y;
    z_s = stage_i.z;
    // Arithmetic shift right floors, as the stage shift requires.
    dx  = y_s >>> IDX;
    dy  = x_s >>> IDX;
    data_d = stage_i;
    if (!y_s[HMA_XW-1]) begin
      data_d.x = x_s + dx;
      data_d.y = y_s - dy;
      data_d.z = z_s + AtanZ;
    end else begin
      data_d.x = x_s - dx;
      data_d.y = y_s + dy;
      data_d.z = z_s - AtanZ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && stage_i.valid) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule

@@ rtl/core/hma_out_cell.sv @@
// Exit cell: wraps the angle, rounds it to the output grid and holds the result.
`timescale 1ns / 1ps
module hma_out_cell import hma_pkg::*; #(
  parameter int unsigned ANGLE_FRACTION_BITS = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hma_stage_t               stage_i,
  output logic                     ready_o,
  input  logic                     take_i,
  output logic                     valid_o,
  output logic [HMA_HEADING_W-1:0] heading_o,
  output logic                     vector_zero_o
);

  localparam int unsigned SH = HMA_ZFRAC - ANGLE_FRACTION_BITS;
  localparam logic signed [HMA_ZW-1:0] FullTurnZ = HMA_ZW'(HMA_FULL_TURN_DEG <<< HMA_ZFRAC);
  localparam logic signed [HMA_ZW-1:0] RoundZ    = HMA_ZW'(1) <<< (SH - 1);
  localparam logic [HMA_ZW-1:0]        FullTurnH =
    HMA_ZW'(HMA_FULL_TURN_DEG <<< ANGLE_FRACTION_BITS);

  logic                     valid_q;
  logic [HMA_HEADING_W-1:0] heading_q, heading_d;
  logic                     zero_q;
  logic signed [HMA_ZW-1:0] z_w, z_r;
  logic [HMA_ZW-1:0]        h;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    z_w = stage_i.z;
    if (z_w < 0) begin
      z_w = z_w + FullTurnZ;
    end
    z_r = z_w + RoundZ;
    h   = HMA_ZW'(z_r >>> SH);
    // A value that rounds up to a full turn reads as zero.
    if (h >= FullTurnH) begin
      h = h - FullTurnH;
    end
    heading_d = stage_i.zero ? '0 : h[HMA_HEADING_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && stage_i.valid) begin
      heading_q <= heading_d;
      zero_q    <= stage_i.zero;
    end
  end

  assign valid_o       = valid_q;
  assign heading_o     = heading_q;
  assign vector_zero_o = zero_q;

endmodule

@@ rtl/core/magnetic_heading_atan2_core.sv @@
// Top level of the magnetometer compass heading core.
// The core turns each magnetometer sample into a compass heading,
// atan2(axis_y, axis_x) in degrees with ANGLE_FRACTION_BITS fraction bits,
// wrapped into [0, 360); axis_z is carried on the sample channel but does not
// enter the result. It takes one item per clock cycle for as long as the
// result side keeps taking items, and each item passes through one entry
// cell, one CORDIC cell per stage and one output register; every cell has
// its own register. At most 24 CORDIC cells are built, however large
// CORDIC_STAGES is. Every cell may load whenever it is empty or its neighbor
// downstream takes its item, so bubbles close up and new items still enter
// while a finished result waits at the output. A sample whose X and Y are
// both zero gives heading 0 with vector_zero set. With ANGLE_FRACTION_BITS
// above 6 the full range no longer fits the 15-bit heading and its top bits
// are dropped. The core has no registers to configure and keeps no state
// from one item to the next.
`timescale 1ns / 1ps
module magnetic_heading_atan2_core import hma_pkg::*; #(
  parameter int unsigned CORDIC_STAGES       = 16,
  parameter int unsigned ANGLE_FRACTION_BITS = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hma_sample_if.sink    in_i,
  hma_heading_if.source out_o
);

  // The angle table holds 24 entries, so deeper chains stop there.
  localparam int unsigned NStages =
    (CORDIC_STAGES > HMA_TABLE_LEN) ? HMA_TABLE_LEN : CORDIC_STAGES;

  // stage[k] feeds rotation cell k (or the exit cell); ready[k] says it can load.
  hma_stage_t stage [NStages+1];
  logic       ready [NStages+1];

  hma_pre_cell u_pre (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .axis_x_i (in_i.axis_x),
    .axis_y_i (in_i.axis_y),
    .ready_o  (in_i.ready),
    .take_i   (ready[0]),
    .stage_o  (stage[0])
  );

  // The rotation cells: cell k rotates by atan(2^-k) toward the X axis.
  for (genvar k = 0; k < NStages; k++) begin : g_cell
    hma_cordic_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stage[k]),
      .ready_o (ready[k]),
      .take_i  (ready[k+1]),
      .stage_o (stage[k+1])
    );
  end

  hma_out_cell #(
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage[NStages]),
    .ready_o       (ready[NStages]),
    .take_i        (out_o.ready),
    .valid_o       (out_o.valid),
    .heading_o     (out_o.heading),
    .vector_zero_o (out_o.vector_zero)
  );

endmodule

@@ rtl/core/hma_checker.sv @@
// Port-level checker for the heading core, bound to its top level.
`timescale 1ns / 1ps
`include "magnetic_heading_atan2_core_assert.svh"
module hma_checker import hma_pkg::*; #(
  parameter int unsigned ANGLE_FRACTION_BITS = 6
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [HMA_HEADING_W-1:0] heading_i,
  input logic                     vector_zero_i
);

  localparam int unsigned FullTurnH = HMA_FULL_TURN_DEG << ANGLE_FRACTION_BITS;
  localparam logic        Narrow    = (ANGLE_FRACTION_BITS <= 6);

  `HMA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `HMA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(heading_i) && $stable(vector_zero_i))
  `HMA_ASSERT_IMPLY(a_zero_heading, clk_i, rst_ni, out_valid_i && vector_zero_i, heading_i == '0)
  `HMA_ASSERT_IMPLY(a_heading_range, clk_i, rst_ni, out_valid_i && Narrow, 32'(heading_i) < FullTurnH)

endmodule

bind magnetic_heading_atan2_core hma_checker #(
  .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
) u_hma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .heading_i     (out_o.heading),
  .vector_zero_i (out_o.vector_zero)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the magnetometer compass heading core.
`timescale 1ns / 1ps
module testbench;
  import hma_pkg::*;

  localparam int unsigned STAGES      = 16;
  localparam int unsigned FRAC_BITS   = 6;
  localparam int          IDLE_PCT    = 21;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          HOLD_CYCLES = 150;
  // Extra wait at the end, after the last expected result has arrived.
  localparam int          DRAIN_CYCLES = 4 * (STAGES + 2);
  localparam int          TIMEOUT_NS  = 400000;

  typedef struct packed {
    logic [HMA_HEADING_W-1:0] heading;
    logic                     vector_zero;
  } heading_t;

  // One row of the directed table. When fixed is set, want holds the
  // expected result typed in by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic signed [HMA_IN_W-1:0] x;
    logic signed [HMA_IN_W-1:0] y;
    logic signed [HMA_IN_W-1:0] z;
    logic                       fixed;
    heading_t                   want;
  } sample_row_t;

  typedef enum int {SHAPE_FULL, SHAPE_SMALL, SHAPE_TINY, SHAPE_EXTREME} axis_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hma_sample_if  smp ();
  hma_heading_if res ();

  magnetic_heading_atan2_core #(
    .CORDIC_STAGES      (STAGES),
    .ANGLE_FRACTION_BITS(FRAC_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (smp),
    .out_o (res)
  );

  heading_t    expected_headings[$];
  sample_row_t directed_rows[$];
  int          mismatches = 0;
  // Set while neither side may idle.
  bit          steady = 1'b0;
  // Raised by the sender to make the receiver hold off for a long stretch.
  bit          hold_request = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bit-exact heading predictor: vectoring CORDIC in degrees with 20 fraction bits.
  function automatic heading_t predict_heading(logic signed [HMA_IN_W-1:0] ax,
                                               logic signed [HMA_IN_W-1:0] ay);
    longint   vx;
    longint   vy;
    longint   ang;
    longint   dx;
    longint   dy;
    longint   hd;
    longint   full_turn;
    int       sh;
    heading_t r;
    r.heading     = '0;
    r.vector_zero = 1'b0;
    if (ax == 0 && ay == 0) begin
      r.vector_zero = 1'b1;
      return r;
    end
    vx  = longint'(ax) * (longint'(1) << HMA_ZFRAC);
    vy  = longint'(ay) * (longint'(1) << HMA_ZFRAC);
    ang = 0;
    // Left half plane: rotate by half a turn so the CORDIC converges.
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      ang = longint'(HMA_HALF_TURN_DEG) << HMA_ZFRAC;
    end
    for (int i = 0; i < STAGES && i < HMA_TABLE_LEN; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        ang = ang + HMA_ATAN_Q20[i];
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        ang = ang - HMA_ATAN_Q20[i];
      end
    end
    if (ang < 0) ang = ang + (longint'(HMA_FULL_TURN_DEG) << HMA_ZFRAC);
    sh = HMA_ZFRAC - FRAC_BITS;
    hd = (ang + (longint'(1) << (sh - 1))) >>> sh;
    // A heading that rounds up to a full turn wraps to zero.
    full_turn = longint'(HMA_FULL_TURN_DEG) << FRAC_BITS;
    if (hd >= full_turn) hd = hd - full_turn;
    r.heading = hd[HMA_HEADING_W-1:0];
    return r;
  endfunction

  function automatic logic signed [HMA_IN_W-1:0] axis_value(axis_shape_e shape);
    int t;
    case (shape)
      SHAPE_SMALL: t = int'($urandom_range(0, 128)) - 64;
      SHAPE_TINY:  t = int'($urandom_range(0, 4)) - 2;
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 6))
          0:       t = -32768;
          1:       t = -32767;
          2:       t = -1;
          3:       t = 0;
          4:       t = 1;
          5:       t = 32766;
          default: t = 32767;
        endcase
      end
      default:     t = int'($urandom);
    endcase
    return t[HMA_IN_W-1:0];
  endfunction

  task automatic add_row(input int x, input int y, input int z, input bit fixed,
                         input int want_heading, input bit want_zero);
    sample_row_t row;
    row.x                = x[HMA_IN_W-1:0];
    row.y                = y[HMA_IN_W-1:0];
    row.z                = z[HMA_IN_W-1:0];
    row.fixed            = fixed;
    row.want.heading     = want_heading[HMA_HEADING_W-1:0];
    row.want.vector_zero = want_zero;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one sample, idling first at random, and record its expected result
  // once the core takes it.
  task automatic offer_sample(input sample_row_t row);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      smp.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp.valid  <= 1'b1;
    smp.axis_x <= row.x;
    smp.axis_y <= row.y;
    smp.axis_z <= row.z;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    if (row.fixed) expected_headings.push_back(row.want);
    else           expected_headings.push_back(predict_heading(row.x, row.y));
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        res.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Every result taken is compared with the oldest expectation.
  always @(posedge clk_i) begin
    heading_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_headings.size() == 0) begin
        report_mismatch($sformatf("unexpected result heading=%0d zero=%0b",
                                  res.heading, res.vector_zero));
      end else begin
        want = expected_headings.pop_front();
        if (res.heading !== want.heading)
          report_mismatch($sformatf("heading got %0d want %0d",
                                    res.heading, want.heading));
        if (res.vector_zero !== want.vector_zero)
          report_mismatch($sformatf("vector_zero got %0b want %0b",
                                    res.vector_zero, want.vector_zero));
      end
    end
  end

  initial begin
    sample_row_t row;
    axis_shape_e sx;
    axis_shape_e sy;
    int          pick;
    smp.valid  = 1'b0;
    smp.axis_x = '0;
    smp.axis_y = '0;
    smp.axis_z = '0;

    // Zero vectors have a fixed answer whatever axis_z holds.
    add_row(0, 0, 0, 1'b1, 0, 1'b1);
    add_row(0, 0, 32767, 1'b1, 0, 1'b1);
    add_row(0, 0, -32768, 1'b1, 0, 1'b1);
    add_row(0, 0, 1, 1'b1, 0, 1'b1);
    // Axes and corners at full scale, including the left-half pre-rotation.
    add_row(32767, 0, 0, 1'b0, 0, 1'b0);
    add_row(-32768, 0, 0, 1'b0, 0, 1'b0);
    add_row(0, 32767, 0, 1'b0, 0, 1'b0);
    add_row(0, -32768, 0, 1'b0, 0, 1'b0);
    add_row(32767, 32767, -1, 1'b0, 0, 1'b0);
    add_row(-32768, -32768, 0, 1'b0, 0, 1'b0);
    add_row(-32768, 32767, 0, 1'b0, 0, 1'b0);
    add_row(32767, -32768, 0, 1'b0, 0, 1'b0);
    // Unit vectors along each axis.
    add_row(1, 0, 0, 1'b0, 0, 1'b0);
    add_row(0, 1, 0, 1'b0, 0, 1'b0);
    add_row(-1, 0, 0, 1'b0, 0, 1'b0);
    add_row(0, -1, 0, 1'b0, 0, 1'b0);
    // Just below the positive X axis the heading rounds to a full turn and wraps; then two lower diagonals.
    add_row(32767, -1, 0, 1'b0, 0, 1'b0);
    add_row(32767, -2, 0, 1'b0, 0, 1'b0);
    add_row(1, -1, 0, 1'b0, 0, 1'b0);
    add_row(-1, -1, 0, 1'b0, 0, 1'b0);
    // Either side of the negative X axis.
    add_row(-32768, 1, 0, 1'b0, 0, 1'b0);
    add_row(-32768, -1, 0, 1'b0, 0, 1'b0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) offer_sample(directed_rows[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Receiver holds off while items keep coming, so the chain fills up.
      if (n == 60) hold_request = 1'b1;
      // Sender goes quiet and waits until the core has drained completely.
      if (n == 130) begin
        @(negedge clk_i);
        smp.valid <= 1'b0;
        while (expected_headings.size() != 0) @(posedge clk_i);
      end
      steady = (n >= 200 && n < 300);

      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        sx = SHAPE_FULL;
        sy = SHAPE_FULL;
      end else if (pick < 60) begin
        sx = SHAPE_SMALL;
        sy = SHAPE_SMALL;
      end else if (pick < 75) begin
        // Close to an axis, where the wrap and the half-turn matter.
        sx = ($urandom_range(0, 1) != 0) ? SHAPE_FULL : SHAPE_TINY;
        sy = (sx == SHAPE_FULL) ? SHAPE_TINY : SHAPE_FULL;
      end else if (pick < 90) begin
        sx = SHAPE_EXTREME;
        sy = SHAPE_EXTREME;
      end else begin
        sx = SHAPE_TINY;
        sy = SHAPE_TINY;
      end
      row.x     = axis_value(sx);
      row.y     = axis_value(sy);
      row.z     = axis_value(SHAPE_FULL);
      row.fixed = 1'b0;
      row.want  = '0;
      offer_sample(row);
    end
    steady = 1'b0;

    @(negedge clk_i);
    smp.valid <= 1'b0;
    while (expected_headings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
